@@ src/tye_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tye_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 20;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_CHUNKS = 4;
  localparam int DIV_SHIFT = 36;
  localparam logic [26:0] DIV_RECIP = 27'd68719477;
  localparam int DIVISOR = 1000;
  localparam int ROUND_BIAS = 500;
  localparam int ANG_W = 27;
  localparam int VEC_W = 36;

  localparam logic signed [ANG_W-1:0] DEG180 = 27'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG90 = 27'sd5898240;
  localparam logic signed [41:0] DEG180_Y = 42'sd11796480;
  localparam logic signed [41:0] DEG360_Y = 42'sd23592960;
  localparam logic signed [41:0] YAW_MAX = 42'sd549755813887;
  localparam logic signed [41:0] YAW_MIN = -42'sd549755813888;

  localparam logic [0:0] REG_GYRO_SCALE = 1'b0;
  localparam logic [0:0] REG_GYRO_OFFSET = 1'b1;
  localparam logic [15:0] GYRO_SCALE_RST = 16'd4000;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic run;
    logic pinit;
    logic pitch;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic run_last;
    logic pitch_last;
    logic out_free;
  } status_t;

  function automatic logic [21:0] step_angle(input logic [4:0] i);
    logic [21:0] a;
    case (i)
      5'd0: a = 22'd2949120;
      5'd1: a = 22'd1740967;
      5'd2: a = 22'd919879;
      5'd3: a = 22'd466945;
      5'd4: a = 22'd234379;
      5'd5: a = 22'd117304;
      5'd6: a = 22'd58666;
      5'd7: a = 22'd29335;
      5'd8: a = 22'd14668;
      5'd9: a = 22'd7334;
      5'd10: a = 22'd3667;
      5'd11: a = 22'd1833;
      5'd12: a = 22'd917;
      5'd13: a = 22'd458;
      5'd14: a = 22'd229;
      5'd15: a = 22'd115;
      5'd16: a = 22'd57;
      5'd17: a = 22'd29;
      5'd18: a = 22'd14;
      5'd19: a = 22'd7;
      5'd20: a = 22'd4;
      5'd21: a = 22'd2;
      5'd22: a = 22'd1;
      default: a = 22'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

@@ src/tye_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tye_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  tye_pkg::status_t st,
  output tye_pkg::cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL1  = 7'b0000010,
    S_MUL2  = 7'b0000100,
    S_RUN   = 7'b0001000,
    S_PINIT = 7'b0010000,
    S_PITCH = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        cmd.run = 1'b1;
        if (st.run_last) state_nxt = S_PINIT;
      end
      S_PINIT: begin
        cmd.pinit = 1'b1;
        state_nxt = S_PITCH;
      end
      S_PITCH: begin
        cmd.pitch = 1'b1;
        if (st.pitch_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.fin = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_MUL1))
    else $error("accepted transaction did not start multiply");
  a_run_to_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && st.run_last) |=> (state_r == S_PINIT))
    else $error("run phase did not hand over to pitch");
  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !st.out_free) |=> (state_r == S_FIN))
    else $error("result dropped while output busy");
`endif

endmodule
`default_nettype wire

@@ src/tye_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tye_dp #(
  parameter int CORDIC_ITERATIONS = tye_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  tye_pkg::cmd_t      cmd,
  output tye_pkg::status_t   st,
  input  wire [95:0]         in_tdata,
  input  wire                cfg_wr_en,
  input  wire [0:0]          cfg_index,
  input  wire [15:0]         cfg_wdata,
  output logic               out_tvalid,
  input  wire                out_tready,
  output logic [95:0]        out_tdata
);

  localparam int CNT_MAX = (tye_pkg::SQRT_STEPS > CORDIC_ITERATIONS) ?
                           tye_pkg::SQRT_STEPS : CORDIC_ITERATIONS;
  localparam int CNT_W = $clog2(CNT_MAX + 1);
  localparam int VW = tye_pkg::VEC_W;
  localparam int AW = tye_pkg::ANG_W;

  logic [15:0] scale_r;
  logic signed [15:0] offset_r;
  logic [31:0] last_tick_r;
  logic signed [39:0] yaw_r;

  logic signed [15:0] ax_r, ay_r, az_r;
  logic rate_neg_r;
  logic [15:0] rate_mag_r;
  logic [15:0] dt_r;
  logic [31:0] sq_r, m1_r;
  logic [63:0] num_r;
  logic [9:0] drem_r;
  logic [25:0] dvt_r;
  logic [51:0] dmul_r;
  logic [63:0] n_r;
  logic [35:0] srem_r;
  logic [31:0] root_r;
  logic signed [VW-1:0] x_r, y_r;
  logic signed [AW-1:0] ang_r;
  logic [CNT_W-1:0] cnt_r;
  logic signed [24:0] roll_r;
  logic out_valid_r;
  logic [95:0] out_data_r;

  logic signed [15:0] in_ax, in_ay, in_az, in_gz;
  logic [31:0] in_tick, tick_diff;
  logic signed [16:0] rate;
  logic signed [VW-1:0] az_ext, ay_ext, sx, sy, cx, cy;
  logic signed [AW-1:0] cang, sa;
  logic [4:0] shamt;
  logic [35:0] rem2, trial;
  logic [25:0] dnext, dback;
  logic [15:0] dquo;
  logic [31:0] sq_sum;
  logic signed [31:0] p_sq;
  logic [47:0] prod;
  logic signed [40:0] inc;
  logic signed [41:0] ysum, ysat, ywrap;
  logic signed [AW-1:0] pclamp;

  assign in_ax = in_tdata[15:0];
  assign in_ay = in_tdata[31:16];
  assign in_az = in_tdata[47:32];
  assign in_gz = in_tdata[63:48];
  assign in_tick = in_tdata[95:64];
  assign tick_diff = in_tick - last_tick_r;
  assign rate = 17'(in_gz) - 17'(offset_r);
  assign az_ext = VW'(in_az) <<< 16;
  assign ay_ext = VW'(in_ay) <<< 16;

  // shared cordic vectoring step
  assign shamt = cnt_r[4:0];
  assign sx = x_r >>> shamt;
  assign sy = y_r >>> shamt;
  assign sa = AW'($signed({1'b0, tye_pkg::step_angle(shamt)}));
  always_comb begin
    cx = x_r;
    cy = y_r;
    cang = ang_r;
    if (y_r > 0) begin
      cx = x_r + sy;
      cy = y_r - sx;
      cang = ang_r + sa;
    end else if (y_r < 0) begin
      cx = x_r - sy;
      cy = y_r + sx;
      cang = ang_r - sa;
    end
  end

  // restoring square root, two bits a cycle
  assign rem2 = {srem_r[33:0], n_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};
  // divide by 1000 one 16 bit chunk at a time, reciprocal multiply then remainder
  assign dnext = {drem_r, num_r[63:48]};
  assign dquo = dmul_r[tye_pkg::DIV_SHIFT +: 16];
  assign dback = dvt_r - 26'(dquo) * 26'(tye_pkg::DIVISOR);

  assign p_sq = az_r * az_r;
  assign sq_sum = sq_r + 32'(p_sq);
  assign prod = m1_r * dt_r;

  assign inc = rate_neg_r ? -41'($signed({2'b00, num_r[38:0]}))
                          : 41'($signed({2'b00, num_r[38:0]}));
  assign ysum = 42'(yaw_r) + 42'(inc);
  always_comb begin
    ysat = ysum;
    if (ysum > tye_pkg::YAW_MAX) ysat = tye_pkg::YAW_MAX;
    if (ysum < tye_pkg::YAW_MIN) ysat = tye_pkg::YAW_MIN;
    ywrap = ysat;
    if (ywrap > tye_pkg::DEG180_Y) ywrap = ywrap - tye_pkg::DEG360_Y;
    if (ywrap < -tye_pkg::DEG180_Y) ywrap = ywrap + tye_pkg::DEG360_Y;
  end

  always_comb begin
    pclamp = ang_r;
    if (ang_r > tye_pkg::DEG90) pclamp = tye_pkg::DEG90;
    if (ang_r < -tye_pkg::DEG90) pclamp = -tye_pkg::DEG90;
  end

  assign st = '{run_last: (cnt_r == CNT_W'(CNT_MAX - 1)),
                pitch_last: (cnt_r == CNT_W'(CORDIC_ITERATIONS - 1)),
                out_free: (!out_valid_r || out_tready)};

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= tye_pkg::GYRO_SCALE_RST;
      offset_r <= '0;
      last_tick_r <= '0;
      yaw_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          tye_pkg::REG_GYRO_SCALE: scale_r <= cfg_wdata;
          tye_pkg::REG_GYRO_OFFSET: offset_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) last_tick_r <= in_tick;
      if (cmd.fin) begin
        yaw_r <= ywrap[39:0];
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r <= in_ax;
      ay_r <= in_ay;
      az_r <= in_az;
      rate_neg_r <= rate[16];
      rate_mag_r <= rate[16] ? 16'(-rate) : rate[15:0];
      dt_r <= (tick_diff > 32'd65535) ? 16'hffff : tick_diff[15:0];
      if (in_az < 0) begin
        x_r <= -az_ext;
        y_r <= -ay_ext;
        ang_r <= (in_ay >= 0) ? tye_pkg::DEG180 : -tye_pkg::DEG180;
      end else begin
        x_r <= az_ext;
        y_r <= ay_ext;
        ang_r <= '0;
      end
    end
    if (cmd.mul1) begin
      sq_r <= 32'(ay_r * ay_r);
      m1_r <= rate_mag_r * scale_r;
    end
    if (cmd.mul2) begin
      n_r <= {sq_sum, 32'd0};
      num_r <= 64'(prod) + 64'(tye_pkg::ROUND_BIAS);
      drem_r <= '0;
      srem_r <= '0;
      root_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.run) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r < CNT_W'(CORDIC_ITERATIONS)) begin
        x_r <= cx;
        y_r <= cy;
        ang_r <= cang;
      end
      if (cnt_r < CNT_W'(tye_pkg::SQRT_STEPS)) begin
        n_r <= {n_r[61:0], 2'b00};
        if (rem2 >= trial) begin
          srem_r <= rem2 - trial;
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          srem_r <= rem2;
          root_r <= {root_r[30:0], 1'b0};
        end
      end
      if (cnt_r < CNT_W'(2 * tye_pkg::DIV_CHUNKS)) begin
        if (!cnt_r[0]) begin
          dvt_r <= dnext;
          dmul_r <= 52'(dnext * tye_pkg::DIV_RECIP);
        end else begin
          drem_r <= dback[9:0];
          num_r <= {num_r[47:0], dquo};
        end
      end
    end
    if (cmd.pinit) begin
      if (ang_r > tye_pkg::DEG180) roll_r <= 25'(tye_pkg::DEG180);
      else if (ang_r < -tye_pkg::DEG180) roll_r <= 25'(-tye_pkg::DEG180);
      else roll_r <= 25'(ang_r);
      x_r <= VW'({1'b0, root_r});
      y_r <= -(VW'(ax_r) <<< 16);
      ang_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.pitch) begin
      cnt_r <= cnt_r + 1'b1;
      x_r <= cx;
      y_r <= cy;
      ang_r <= cang;
    end
    if (cmd.fin) begin
      out_data_r <= {7'd0, ywrap[39:0], pclamp[23:0], roll_r};
    end
  end

`ifndef ASSERT_OFF
  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.fin))
    else $error("result appeared without finish");
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(out_data_r))
    else $error("stalled result changed");
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> (!out_valid_r || out_tready))
    else $error("finish overwrote pending result");
`endif

endmodule
`default_nettype wire

@@ src/tilt_and_yaw_estimator.sv @@
// an input transaction passes through the load step, both multiply steps, the run pass, pitch init,
// the pitch pass and finish; a new transaction is taken only after the last one finishes, its
// occupancy set by the 32 step square root pass followed by the pitch pass of the shared cordic
// a result waiting in the output register stalls only the finish step
// reset: synchronous active low, clears yaw, last tick, gyro offset, output valid, scale to 4000
`timescale 1ns / 1ps
`default_nettype none
module tilt_and_yaw_estimator #(
  parameter int CORDIC_ITERATIONS = tye_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire [95:0]  in_tdata,   // accel_x, accel_y, accel_z, gyro_z, tick_ms
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [95:0] out_tdata,  // roll_angle, pitch_angle, yaw_angle, zero pad
  input  wire         cfg_wr_en,
  input  wire [0:0]   cfg_index,
  input  wire [15:0]  cfg_wdata
);

  tye_pkg::cmd_t cmd;
  tye_pkg::status_t st;

  tye_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  tye_dp #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
